// ----- hdl/assert_macros.svh -----
// Assertion macros used by the allocator top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- hdl/bba_pkg.sv -----
// Package with constants and types of the buddy block allocator.
package bba_pkg;
  localparam int TREE_LEVELS_DEF  = 8;
  localparam int MEMORY_BYTES_DEF = 65536;
  localparam logic [6:0] HEADER_RESET = 7'd8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LARGE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_ANC, S_SUB,
    S_FSUB, S_FBUD, S_FBUD_WAIT, S_FUP, S_FUP_WAIT, S_DONE
  } state_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       wdata;
    logic [15:0] addr;
  } mem_req_t;
endpackage

// ----- hdl/bba_if.sv -----
// Valid/ready stream interfaces for requests and results.
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [16:0] request_bytes;
  logic [7:0]  free_index;
  modport source (output valid, operation, request_bytes, free_index, input ready);
  modport sink (input valid, operation, request_bytes, free_index, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  node_index;
  logic [15:0] block_start;
  logic [16:0] block_bytes;
  modport source (output valid, status, node_index, block_start, block_bytes, input ready);
  modport sink (input valid, status, node_index, block_start, block_bytes, output ready);
endinterface

// ----- hdl/buddy_block_allocator_unit.sv -----
// An allocate scans one tree level for a clear node, marks its ancestors, then marks its
// subtree; a free clears the subtree, then climbs, clearing each parent while the buddy is clear.
// Throughput: one item at a time, set by the single-port mark memory.
// Reset clears control and starts a clearing pass over every node of the mark memory;
// no item is accepted until it ends.
module buddy_block_allocator_unit #(
  parameter int TREE_LEVELS  = bba_pkg::TREE_LEVELS_DEF,
  parameter int MEMORY_BYTES = bba_pkg::MEMORY_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [6:0] cfg_wdata,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;
  `include "assert_macros.svh"

  logic [6:0] header_bytes;
  mem_req_t   mem;
  logic       mem_rdata, busy;

  // Header size register.
  always_ff @(posedge clk) begin
    if (rst) header_bytes <= HEADER_RESET;
    else if (cfg_we) header_bytes <= cfg_wdata;
  end

  bba_seq #(.TREE_LEVELS(TREE_LEVELS), .MEMORY_BYTES(MEMORY_BYTES)) u_seq (
    .clk, .rst, .header_bytes, .req, .rsp, .mem, .mem_rdata, .busy
  );

  bba_mark_mem #(.TREE_LEVELS(TREE_LEVELS)) u_mem (.clk, .req(mem), .rdata(mem_rdata));

  // Checks on the sequencer.
  `ASSERT_IMPL(a_no_rdwr, clk, rst, mem.rd, !mem.wr)
  `ASSERT_IMPL(a_ready_idle, clk, rst, req.ready, !rsp.valid)
  `ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready, busy)
endmodule

// ----- hdl/bba_mark_mem.sv -----
// Mark bit memory: one shared address for write and read, registered read data.
module bba_mark_mem #(
  parameter int TREE_LEVELS = 8
) (
  input  logic              clk,
  input  bba_pkg::mem_req_t req,
  output logic              rdata
);
  import bba_pkg::*;
  localparam int NODES = 1 << TREE_LEVELS;
  logic marks [NODES];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr) marks[req.addr[TREE_LEVELS-1:0]] <= req.wdata;
    if (req.rd) rdata <= marks[req.addr[TREE_LEVELS-1:0]];
  end
endmodule

// ----- hdl/bba_seq.sv -----
// Sequencer that walks the mark memory for allocate and free items.
module bba_seq #(
  parameter int TREE_LEVELS  = 8,
  parameter int MEMORY_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        header_bytes,
  bba_req_if.sink           req,
  bba_rsp_if.source         rsp,
  output bba_pkg::mem_req_t mem,
  input  logic              mem_rdata,
  output logic              busy
);
  import bba_pkg::*;
  localparam int NODES = 1 << TREE_LEVELS;
  localparam int AW = TREE_LEVELS + 1;
  localparam int LW = $clog2(TREE_LEVELS);
  localparam int MBW = $clog2(MEMORY_BYTES) + 1;

  state_t state, state_next;
  logic [AW-1:0] ptr, ptr_next, node, node_next;
  logic [AW-1:0] row_first, row_first_next, row_cnt, row_cnt_next, row_j, row_j_next;
  logic [LW-1:0] level, level_next;
  logic [1:0]  o_status, o_status_next;
  logic [7:0]  o_node, o_node_next;
  logic [15:0] o_start, o_start_next;
  logic [16:0] o_bytes, o_bytes_next;
  logic        o_valid, o_valid_next;

  logic [17:0] total;
  logic [LW-1:0] lvl_pick;
  logic [MBW-1:0] blk;
  logic [MBW+AW-1:0] start_w;

  assign total = {1'b0, req.request_bytes} + 18'(header_bytes);

  // Deepest level whose block still holds the request.
  always_comb begin
    lvl_pick = '0;
    for (int l = 1; l < TREE_LEVELS; l++) begin
      if ((64'(MEMORY_BYTES) >> l) >= 64'(total)) lvl_pick = LW'(l);
    end
  end

  assign blk = MBW'(MBW'(MEMORY_BYTES) >> level);
  assign start_w = (MBW+AW)'(blk) * (MBW+AW)'(node - (AW'(1) << level));

  assign req.ready = (state == S_IDLE) && !o_valid;
  assign rsp.valid = o_valid;
  assign rsp.status = o_status;
  assign rsp.node_index = o_node;
  assign rsp.block_start = o_start;
  assign rsp.block_bytes = o_bytes;
  assign busy = (state != S_IDLE) || o_valid;

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      o_valid <= o_valid_next;
    end
    node <= node_next; row_first <= row_first_next; row_cnt <= row_cnt_next;
    row_j <= row_j_next; level <= level_next;
    o_status <= o_status_next; o_node <= o_node_next;
    o_start <= o_start_next; o_bytes <= o_bytes_next;
  end

  // Next state and memory requests.
  always_comb begin
    state_next = state; ptr_next = ptr; node_next = node;
    row_first_next = row_first; row_cnt_next = row_cnt; row_j_next = row_j;
    level_next = level; o_status_next = o_status; o_node_next = o_node;
    o_start_next = o_start; o_bytes_next = o_bytes;
    o_valid_next = o_valid && !rsp.ready;
    mem = '0;
    unique case (state)
      S_CLEAR: begin
        mem.wr = 1'b1; mem.addr = 16'(ptr);
        ptr_next = ptr + AW'(1);
        if (ptr == AW'(NODES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) begin
          o_status_next = ST_OK; o_node_next = '0; o_start_next = '0; o_bytes_next = '0;
          if (req.operation == OP_FREE) begin
            o_node_next = req.free_index;
            node_next = AW'(req.free_index);
            if (req.free_index == 8'd0 || int'(req.free_index) >= NODES) begin
              state_next = S_DONE;
            end else begin
              row_first_next = AW'(req.free_index); row_cnt_next = AW'(1);
              row_j_next = '0; state_next = S_FSUB;
            end
          end else if (total > 18'(MEMORY_BYTES)) begin
            o_status_next = ST_LARGE; state_next = S_DONE;
          end else begin
            level_next = lvl_pick;
            ptr_next = AW'(1) << lvl_pick;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem.rd = 1'b1; mem.addr = 16'(ptr); state_next = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (!mem_rdata) begin
          node_next = ptr; row_first_next = ptr; row_cnt_next = AW'(1);
          row_j_next = '0; ptr_next = ptr >> 1; state_next = S_ANC;
        end else if (ptr == (AW'(2) << level) - AW'(1)) begin
          o_status_next = ST_FULL; state_next = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1); state_next = S_SCAN;
        end
      end
      S_ANC: begin
        if (ptr == '0) state_next = S_SUB;
        else begin
          mem.wr = 1'b1; mem.wdata = 1'b1; mem.addr = 16'(ptr); ptr_next = ptr >> 1;
        end
      end
      S_SUB, S_FSUB: begin
        if (row_first >= AW'(NODES)) begin
          if (state == S_SUB) begin
            o_node_next = 8'(node);
            o_start_next = 16'(start_w);
            o_bytes_next = 17'(blk);
            state_next = S_DONE;
          end else state_next = S_FBUD;
        end else begin
          mem.wr = 1'b1; mem.wdata = (state == S_SUB);
          mem.addr = 16'(row_first + row_j);
          if (row_j == row_cnt - AW'(1)) begin
            row_j_next = '0; row_first_next = row_first << 1; row_cnt_next = row_cnt << 1;
          end else row_j_next = row_j + AW'(1);
        end
      end
      S_FBUD, S_FUP: begin
        mem.rd = 1'b1; mem.addr = 16'(node ^ AW'(1));
        state_next = (state == S_FBUD) ? S_FBUD_WAIT : S_FUP_WAIT;
      end
      S_FBUD_WAIT, S_FUP_WAIT: begin
        if (state == S_FUP_WAIT && mem_rdata) state_next = S_DONE;
        else if (state == S_FBUD_WAIT && mem_rdata) state_next = S_DONE;
        else if ((node >> 1) == '0) state_next = S_DONE;
        else begin
          mem.wr = 1'b1; mem.addr = 16'(node >> 1);
          node_next = node >> 1; state_next = S_FUP;
        end
      end
      S_DONE: begin
        o_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- dv/bba_tb_if.sv -----
// Interfaces are provided by the RTL; this file holds the testbench scoreboard class.
`timescale 1ns / 1ps
package bba_tb_pkg;
  import bba_pkg::*;

  // Expected allocator result of one transfer.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  node_index;
    logic [15:0] block_start;
    logic [16:0] block_bytes;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            marks[256];
    logic [6:0]    header_bytes;
    alloc_result_t pending[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   n_alloc_ok, n_full, n_large;

    function new();
      foreach (marks[i]) marks[i] = 1'b0;
      header_bytes = HEADER_RESET;
      errors = 0;
      checked = 0;
    endfunction

    // Sets or clears a node and every node below it.
    function void paint_subtree(int root, bit value);
      int first;
      int count;
      first = root;
      count = 1;
      while (first < 256) begin
        for (int j = 0; j < count && first + j < 256; j++) marks[first + j] = value;
        first = first << 1;
        count = count << 1;
      end
    endfunction

    // Updates the tree for one accepted request and queues its result.
    function void note_request(logic op, logic [16:0] req_bytes, logic [7:0] fidx);
      alloc_result_t r;
      int unsigned need;
      int level;
      int unsigned size;
      int base;
      int found;
      int p;
      r = '0;
      if (op == OP_FREE) begin
        r.node_index = fidx;
        if (fidx != 0) begin
          paint_subtree(int'(fidx), 1'b0);
          if (!marks[fidx ^ 8'd1]) begin
            p = int'(fidx) >> 1;
            while (p > 0) begin
              marks[p] = 1'b0;
              if (marks[p ^ 1]) break;
              p = p >> 1;
            end
          end
        end
      end else begin
        need = 32'(req_bytes) + 32'(header_bytes);
        if (need > 65536) begin
          r.status = ST_LARGE;
        end else begin
          level = 0;
          size = 65536;
          while (level < 7 && (size >> 1) >= need) begin
            level++;
            size = size >> 1;
          end
          base = 1 << level;
          found = 0;
          for (int n = base; n < 2 * base; n++) begin
            if (!marks[n]) begin
              found = n;
              break;
            end
          end
          if (found == 0) begin
            r.status = ST_FULL;
          end else begin
            for (p = found >> 1; p > 0; p = p >> 1) marks[p] = 1'b1;
            paint_subtree(found, 1'b1);
            r.status = ST_OK;
            r.node_index = 8'(found);
            r.block_start = 16'(size * 32'(found - base));
            r.block_bytes = 17'(size);
          end
        end
      end
      pending.push_back(r);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status == ST_OK && got.block_bytes != 0) n_alloc_ok++;
      if (got.status == ST_FULL) n_full++;
      if (got.status == ST_LARGE) n_large++;
      if (got.status != exp.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      end
      if (got.node_index != exp.node_index) begin
        errors++;
        $display("%0t: node_index expected %0d actual %0d", $time, exp.node_index,
                 got.node_index);
      end
      if (got.block_start != exp.block_start) begin
        errors++;
        $display("%0t: block_start expected %0d actual %0d", $time, exp.block_start,
                 got.block_start);
      end
      if (got.block_bytes != exp.block_bytes) begin
        errors++;
        $display("%0t: block_bytes expected %0d actual %0d", $time, exp.block_bytes,
                 got.block_bytes);
      end
    endfunction
  endclass
endpackage

// ----- dv/buddy_block_allocator_unit_tb.sv -----
// Testbench top for the buddy block allocator with predictor scoreboard.
`timescale 1ns / 1ps
module buddy_block_allocator_unit_tb;
  import bba_pkg::*;
  import bba_tb_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent = 0;
  alloc_scoreboard sb;

  bba_req_if req ();
  bba_rsp_if rsp ();

  buddy_block_allocator_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.operation = OP_ALLOC;
    req.request_bytes = '0;
    req.free_index = '0;
    rsp.ready = 1'b0;
  end

  // Receiver side: random stalls, and every result transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.status, rsp.node_index, rsp.block_start, rsp.block_bytes});
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drives one request and holds it until the transfer happens.
  // Valid stays high afterwards; idling and draining drop it.
  task automatic send_request(logic op, logic [16:0] nbytes, logic [7:0] fidx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.request_bytes <= nbytes;
    req.free_index <= fidx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, nbytes, fidx);
    sent++;
  endtask

  // Waits until every result is back, then lets the block settle.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_header(logic [6:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.header_bytes = value;
  endtask

  // Request size biased toward small blocks so the tree fills and splits often.
  function automatic logic [16:0] pick_size();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 5) return 17'(65536 - $urandom_range(70));
    if (k < 10) return 17'($urandom_range(17'h1FFFF));
    if (k < 20) return 17'($urandom_range(65536));
    return 17'($urandom_range((1 << $urandom_range(16, 8)) - 1));
  endfunction

  task automatic random_phase(int n);
    logic [7:0] idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) begin
        send_request(OP_ALLOC, pick_size(), 8'($urandom_range(255)));
      end else begin
        idx = 8'($urandom_range(255));
        // Mostly free a node that is marked, so blocks get recycled.
        for (int t = 0; t < 8 && $urandom_range(3) != 0; t++) begin
          if (sb.marks[idx] && idx != 0) break;
          idx = 8'($urandom_range(255, 1));
        end
        send_request(OP_FREE, 17'($urandom_range(17'h1FFFF)), idx);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, too large, tiny, level full and out-of-tree frees.
    send_request(OP_ALLOC, 17'd65528, 8'd0);
    send_request(OP_ALLOC, 17'd65529, 8'd0);
    send_request(OP_ALLOC, 17'h1FFFF, 8'hFF);
    send_request(OP_ALLOC, 17'd0, 8'd0);
    send_request(OP_FREE, 17'h1FFFF, 8'd1);
    send_request(OP_FREE, 17'd0, 8'd0);
    send_request(OP_FREE, 17'd0, 8'd255);
    for (int i = 0; i < 9; i++) send_request(OP_ALLOC, 17'd32760, 8'd0);
    send_request(OP_FREE, 17'd0, 8'd2);
    send_request(OP_FREE, 17'd0, 8'd3);
    send_request(OP_ALLOC, 17'd0, 8'd0);
    send_request(OP_FREE, 17'd0, 8'd128);
    send_request(OP_FREE, 17'd0, 8'd200);
    write_header(7'd0);
    send_request(OP_ALLOC, 17'd65536, 8'd0);
    send_request(OP_FREE, 17'd0, 8'd1);
    write_header(7'd64);
    send_request(OP_ALLOC, 17'd65472, 8'd0);
    send_request(OP_ALLOC, 17'd65473, 8'd0);
    send_request(OP_FREE, 17'd0, 8'd1);

    // Random phases under the different idling mixes and header settings.
    write_header(7'd127);
    random_phase(400);
    drain();
    send_idle_pct = 64;
    write_header(7'($urandom_range(64)));
    random_phase(400);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    write_header(7'd0);
    random_phase(400);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    write_header(7'd64);
    random_phase(400);

    drain();
    $display("Ran %0d requests, checked %0d results: %0d allocs ok, %0d full, %0d too large.",
             sent, sb.checked, sb.n_alloc_ok, sb.n_full, sb.n_large);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS buddy_block_allocator_unit");
    end else begin
      $display("FAIL buddy_block_allocator_unit");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60ms;
    $display("FAIL buddy_block_allocator_unit");
    $finish;
  end
endmodule

// ----- buddy_block_allocator_unit.f -----
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_mark_mem.sv
hdl/bba_seq.sv
hdl/buddy_block_allocator_unit.sv
dv/bba_tb_if.sv
dv/buddy_block_allocator_unit_tb.sv
